// ----- rtl/positional_char_buffer_macros.svh -----
`ifndef POSITIONAL_CHAR_BUFFER_MACROS_SVH
`define POSITIONAL_CHAR_BUFFER_MACROS_SVH

// same-cycle implication, off during reset
`define PCB_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("positional_char_buffer: same-cycle check failed");

// next-cycle implication, off during reset
`define PCB_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("positional_char_buffer: next-cycle check failed");

// state right after a reset cycle
`define PCB_ASSERT_RESET(lbl, cons) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("positional_char_buffer: reset check failed");

`endif

// ----- rtl/pcb_pkg.sv -----
`default_nettype none
package pcb_pkg;

   localparam int CAPACITY_DEF = 4096;
   localparam int POS_W        = 13;
   localparam int CHAR_W       = 8;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [CHAR_W-1:0] char_type;

   typedef enum logic [1:0] {
      FN_CLEAR  = 2'd0,
      FN_APPEND = 2'd1,
      FN_INSERT = 2'd2,
      FN_READ   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       clear;
      logic       rd_shift;
      logic       wr_shift;
      logic       rd_pos;
      logic       put;
      logic       set_rsp;
      logic       use_rdata;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     full;
      logic     at_slot;
      logic     at_slot_next;
      logic     read_ok;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/positional_char_buffer.sv -----
// Ordered byte sequence of up to CAPACITY characters in one flat memory
// (one read and one write port). One item at a time: req_stall stays high
// from acceptance until its single result beat is taken. In an append or
// insert, every character at or past the slot moves up one place by a read
// then a write on the memory port. The memory needs no clearing pass; bytes
// beyond the length are never returned.
`default_nettype none
module positional_char_buffer #(
   parameter int CAPACITY = pcb_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_func,
   input  wire pcb_pkg::pos_type  req_position,
   input  wire pcb_pkg::char_type req_character,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pcb_pkg::char_type      rsp_read_char,
   output logic [1:0]             rsp_status,
   output pcb_pkg::pos_type       rsp_length
);
   import pcb_pkg::*;

   cmd_type cmd;
   sts_type sts;

   pcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcb_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_character (req_character),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_read_char (rsp_read_char),
      .rsp_status    (rsp_status),
      .rsp_length    (rsp_length)
   );

endmodule
`default_nettype wire

// ----- rtl/pcb_ctrl.sv -----
`default_nettype none
module pcb_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire pcb_pkg::sts_type sts,
   output pcb_pkg::cmd_type     cmd
);
   import pcb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (sts.func)
               FN_CLEAR: state_in = S_RESP;
               FN_READ:  state_in = sts.read_ok ? S_READ : S_RESP;
               default: begin
                  if (sts.full) state_in = S_RESP;
                  else if (sts.at_slot) state_in = S_PUT;
                  else state_in = S_SHIFT_RD;
               end
            endcase
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = sts.at_slot_next ? S_PUT : S_SHIFT_RD;
         S_PUT:      state_in = S_RESP;
         S_READ:     state_in = S_RESP;
         S_RESP: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_status = ST_OK;
      case (state_ff)
         S_IDLE: cmd.load = req_valid;
         S_DECODE: begin
            case (sts.func)
               FN_CLEAR: begin
                  cmd.clear   = 1'b1;
                  cmd.set_rsp = 1'b1;
               end
               FN_READ: begin
                  if (sts.read_ok) begin
                     cmd.rd_pos = 1'b1;
                  end else begin
                     cmd.set_rsp    = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                  end
               end
               default: begin
                  if (sts.full) begin
                     cmd.set_rsp    = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end
               end
            endcase
         end
         S_SHIFT_RD: cmd.rd_shift = 1'b1;
         S_SHIFT_WR: cmd.wr_shift = 1'b1;
         S_PUT: begin
            cmd.put     = 1'b1;
            cmd.set_rsp = 1'b1;
         end
         S_READ: begin
            cmd.set_rsp   = 1'b1;
            cmd.use_rdata = 1'b1;
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule
`default_nettype wire

// ----- rtl/pcb_dp.sv -----
`default_nettype none
module pcb_dp #(
   parameter int CAPACITY = pcb_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        req_func,
   input  wire pcb_pkg::pos_type  req_position,
   input  wire pcb_pkg::char_type req_character,
   input  wire pcb_pkg::cmd_type  cmd,
   output pcb_pkg::sts_type       sts,
   output pcb_pkg::char_type      rsp_read_char,
   output logic [1:0]             rsp_status,
   output pcb_pkg::pos_type       rsp_length
);
   import pcb_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

   char_type mem [CAPACITY];

   logic [LEN_W-1:0]  len_ff;
   logic [ADDR_W-1:0] ptr_ff, slot_ff;
   func_type          func_ff;
   pos_type           pos_ff;
   char_type          char_ff, rdata_ff, rsp_char_ff;
   status_type        rsp_status_ff;

   logic [CMP_W-1:0]  len_w, pos_w, req_pos_w, slot_w, rdpos_w;
   logic [ADDR_W-1:0] ptr_dec, rd_addr, wr_addr;
   char_type          wr_data;
   logic              wr_en, rd_en;

   assign len_w     = CMP_W'(len_ff);
   assign pos_w     = CMP_W'(pos_ff);
   assign req_pos_w = CMP_W'(req_position);
   assign slot_w    = (func_type'(req_func) == FN_APPEND || req_pos_w >= len_w) ?
                      len_w : req_pos_w;
   assign rdpos_w   = pos_w - CMP_W'(1);
   assign ptr_dec   = ptr_ff - ADDR_W'(1);

   assign rd_en   = cmd.rd_shift | cmd.rd_pos;
   assign rd_addr = cmd.rd_pos ? rdpos_w[ADDR_W-1:0] : ptr_dec;
   assign wr_en   = cmd.wr_shift | cmd.put;
   assign wr_addr = cmd.put ? slot_ff : ptr_ff;
   assign wr_data = cmd.put ? char_ff : rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (cmd.clear) begin
         len_ff <= '0;
      end else if (cmd.put) begin
         len_ff <= len_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= func_type'(req_func);
         pos_ff  <= req_position;
         char_ff <= req_character;
         slot_ff <= slot_w[ADDR_W-1:0];
         ptr_ff  <= len_w[ADDR_W-1:0];
      end else if (cmd.wr_shift) begin
         ptr_ff <= ptr_dec;
      end
      if (cmd.set_rsp) begin
         rsp_char_ff   <= cmd.use_rdata ? rdata_ff : '0;
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   assign sts.func         = func_ff;
   assign sts.full         = (len_ff == LEN_W'(CAPACITY));
   assign sts.at_slot      = (ptr_ff == slot_ff);
   assign sts.at_slot_next = (ptr_dec == slot_ff);
   assign sts.read_ok      = (pos_ff != '0) && (pos_w <= len_w);

   assign rsp_read_char = rsp_char_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_length    = len_w[POS_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/pcb_checker.sv -----
`default_nettype none
`include "positional_char_buffer_macros.svh"
module pcb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_read_char,
   input wire logic [1:0]  rsp_status,
   input wire logic [12:0] rsp_length
);
   import pcb_pkg::*;

   `PCB_ASSERT_RESET(a_reset_idle, !rsp_valid && !req_stall)
   `PCB_ASSERT_NOW(a_busy_while_rsp, rsp_valid, req_stall)
   `PCB_ASSERT_NOW(a_status_code, rsp_valid, rsp_status <= ST_RANGE)
   `PCB_ASSERT_NOW(a_err_zero_char, rsp_valid && rsp_status != ST_OK, rsp_read_char == 8'd0)
   `PCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_read_char) && $stable(rsp_status) && $stable(rsp_length))
endmodule

bind positional_char_buffer pcb_checker u_pcb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_char (rsp_read_char),
   .rsp_status    (rsp_status),
   .rsp_length    (rsp_length)
);
`default_nettype wire
